### rtl/core/stq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted timer queue package
// Shared types, widths and operation and status codes.
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned ID_W      = 16;
  localparam int unsigned DELAY_W   = 32;
  localparam int unsigned TIME_W    = 48;

  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_TICK   = 2'd2;

  localparam logic [2:0] ST_ADDED    = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_REMOVED  = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_FIRED    = 3'd4;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef struct packed {
    logic [1:0]         func;
    logic [ID_W-1:0]    timer_id;
    logic [DELAY_W-1:0] delay;
    logic               periodic;
    logic [TIME_W-1:0]  now;
  } cmd_t;

  function automatic logic [TIME_W-1:0] sat_expiry(input logic [TIME_W-1:0] now,
                                                   input logic [DELAY_W-1:0] delay);
    logic [TIME_W:0] sum;
    sum = {1'b0, now} + {{(TIME_W+1-DELAY_W){1'b0}}, delay};
    return sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
  endfunction

endpackage
`default_nettype wire

### rtl/core/sorted_timer_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted timer queue
// Keeps up to DEPTH timers in expiry order and fires them on tick.
// ----------------------------------------------------------------------------
// The engine walks its slot registers one entry a cycle. A tick first scans
// for due timers, then fires each one in turn (popping the head and
// re-inserting a periodic one); a stalled result holds the engine. A
// two-entry command queue lets new items be taken while the engine is busy.
module sorted_timer_queue #(
  parameter int unsigned DEPTH = stq_pkg::DEPTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [1:0]                in_func,
  input  wire logic [stq_pkg::ID_W-1:0]  in_timer_id,
  input  wire logic [stq_pkg::DELAY_W-1:0] in_delay,
  input  wire logic                      in_periodic,
  input  wire logic [stq_pkg::TIME_W-1:0] in_now,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [2:0]                     out_status,
  output logic [stq_pkg::ID_W-1:0]       out_fired_id,
  output logic                           out_fired_periodic,
  output logic                           out_last
);
  import stq_pkg::*;

  cmd_t in_cmd, q_cmd;
  logic q_valid, q_ready;

  assign in_cmd = '{func: in_func, timer_id: in_timer_id, delay: in_delay,
                    periodic: in_periodic, now: in_now};

  stq_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_cmd(in_cmd), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
  );

  stq_engine #(.DEPTH(DEPTH)) u_engine (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
    .q_cmd(q_cmd), .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_fired_id(out_fired_id),
    .out_fired_periodic(out_fired_periodic), .out_last(out_last)
  );

endmodule
`default_nettype wire

### rtl/core/stq_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted timer queue front end
// Accepts commands, drops unused codes and queues the rest for the engine.
// ----------------------------------------------------------------------------
module stq_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire stq_pkg::cmd_t in_cmd,
  output logic               q_valid,
  input  wire logic          q_ready,
  output stq_pkg::cmd_t      q_cmd
);
  import stq_pkg::*;

  cmd_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wp_r, rp_r;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready &&
                    (in_cmd.func == FUNC_ADD || in_cmd.func == FUNC_REMOVE ||
                     in_cmd.func == FUNC_TICK);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = q_r[rp_r];
  assign pop      = q_valid && q_ready;

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= in_cmd;
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (!rst_n) (cnt_r == 2'd0) |-> !pop)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n)
      (cnt_r == 2'd2) |=> (cnt_r != 2'd0))
    else $error("full queue emptied in one cycle");

endmodule
`default_nettype wire

### rtl/core/stq_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted timer queue engine
// Holds the sorted slots and walks them one entry a cycle for each command.
// ----------------------------------------------------------------------------
module stq_engine #(
  parameter int unsigned DEPTH = stq_pkg::DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  q_valid,
  output logic                       q_ready,
  input  wire stq_pkg::cmd_t         q_cmd,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [2:0]                 out_status,
  output logic [stq_pkg::ID_W-1:0]   out_fired_id,
  output logic                       out_fired_periodic,
  output logic                       out_last
);
  import stq_pkg::*;

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FIND = 3'd1;
  localparam logic [2:0] S_SHUP = 3'd2;
  localparam logic [2:0] S_RMSH = 3'd3;
  localparam logic [2:0] S_TICK = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;
  localparam logic [2:0] S_TCNT = 3'd6;

  logic [ID_W-1:0]    s_id  [DEPTH];
  logic               s_per [DEPTH];
  logic [DELAY_W-1:0] s_dly [DEPTH];
  logic [TIME_W-1:0]  s_exp [DEPTH];

  logic [2:0]        st_r;
  logic [CW-1:0]     used_r, idx_r, pos_r, nfire_r;
  cmd_t              cmd_r;
  logic [TIME_W-1:0] exp_r;
  logic [ID_W-1:0]   ins_id_r;
  logic              ins_per_r;
  logic [DELAY_W-1:0] ins_dly_r;
  logic              tick_r;
  logic              ov_r;
  logic [2:0]        o_st_r;
  logic [ID_W-1:0]   o_id_r;
  logic              o_per_r;
  logic              o_last_r;

  logic [IW-1:0] ix, ixm1, ixp1;
  assign ix   = idx_r[IW-1:0];
  assign ixm1 = ix - 1'b1;
  assign ixp1 = ix + 1'b1;

  assign q_ready            = (st_r == S_IDLE);
  assign out_valid          = ov_r;
  assign out_status         = o_st_r;
  assign out_fired_id       = o_id_r;
  assign out_fired_periodic = o_per_r;
  assign out_last           = o_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      used_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      if (ov_r && out_ready) ov_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (q_valid) begin
            cmd_r <= q_cmd;
            idx_r <= '0;
            unique case (q_cmd.func)
              FUNC_ADD: begin
                if (used_r == CW'(DEPTH)) begin
                  o_st_r <= ST_FULL; o_id_r <= q_cmd.timer_id;
                  o_per_r <= q_cmd.periodic; o_last_r <= 1'b1;
                  ov_r <= 1'b1; st_r <= S_EMIT;
                end else begin
                  ins_id_r  <= q_cmd.timer_id;
                  ins_per_r <= q_cmd.periodic;
                  ins_dly_r <= q_cmd.delay;
                  exp_r     <= sat_expiry(q_cmd.now, q_cmd.delay);
                  tick_r    <= 1'b0;
                  st_r      <= S_FIND;
                end
              end
              FUNC_REMOVE: begin
                tick_r <= 1'b0;
                st_r   <= S_FIND;
              end
              default: begin
                tick_r <= 1'b1;
                st_r   <= S_TCNT;
              end
            endcase
          end
        end
        S_TCNT: begin
          // Due timers are counted first so that a re-armed periodic timer
          // cannot fire twice in one tick.
          if (idx_r == used_r || s_exp[ix] > cmd_r.now) begin
            nfire_r <= idx_r;
            st_r    <= S_TICK;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_FIND: begin
          if (cmd_r.func == FUNC_REMOVE) begin
            if (idx_r == used_r) begin
              o_st_r <= ST_NOTFOUND; o_id_r <= cmd_r.timer_id;
              o_per_r <= cmd_r.periodic; o_last_r <= 1'b1;
              ov_r <= 1'b1; st_r <= S_EMIT;
            end else if (s_id[ix] == cmd_r.timer_id && s_per[ix] == cmd_r.periodic) begin
              st_r <= S_RMSH;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end else begin
            if (idx_r == used_r || s_exp[ix] > exp_r) begin
              pos_r <= idx_r;
              idx_r <= used_r;
              st_r  <= S_SHUP;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        S_SHUP: begin
          if (idx_r == pos_r) begin
            s_id[ix] <= ins_id_r; s_per[ix] <= ins_per_r;
            s_dly[ix] <= ins_dly_r; s_exp[ix] <= exp_r;
            used_r <= used_r + 1'b1;
            if (tick_r) begin
              st_r <= S_TICK;
            end else begin
              o_st_r <= ST_ADDED; o_id_r <= ins_id_r;
              o_per_r <= ins_per_r; o_last_r <= 1'b1;
              ov_r <= 1'b1; st_r <= S_EMIT;
            end
          end else begin
            s_id[ix] <= s_id[ixm1]; s_per[ix] <= s_per[ixm1];
            s_dly[ix] <= s_dly[ixm1]; s_exp[ix] <= s_exp[ixm1];
            idx_r <= idx_r - 1'b1;
          end
        end
        S_RMSH: begin
          if (idx_r + 1'b1 >= used_r) begin
            used_r <= used_r - 1'b1;
            if (tick_r) begin
              idx_r <= '0;
              st_r  <= ins_per_r ? S_FIND : S_TICK;
            end else begin
              o_st_r <= ST_REMOVED; o_id_r <= cmd_r.timer_id;
              o_per_r <= cmd_r.periodic; o_last_r <= 1'b1;
              ov_r <= 1'b1; st_r <= S_EMIT;
            end
          end else begin
            s_id[ix] <= s_id[ixp1]; s_per[ix] <= s_per[ixp1];
            s_dly[ix] <= s_dly[ixp1]; s_exp[ix] <= s_exp[ixp1];
            idx_r <= idx_r + 1'b1;
          end
        end
        S_TICK: begin
          if (nfire_r == '0) begin
            st_r <= S_EMIT;
          end else if (!ov_r) begin
            o_st_r <= ST_FIRED; o_id_r <= s_id[0]; o_per_r <= s_per[0];
            o_last_r <= (nfire_r == CW'(1));
            ov_r <= 1'b1;
            ins_id_r  <= s_id[0];
            ins_per_r <= s_per[0];
            ins_dly_r <= s_dly[0];
            exp_r     <= sat_expiry(cmd_r.now, s_dly[0]);
            nfire_r   <= nfire_r - 1'b1;
            idx_r <= '0;
            st_r  <= S_RMSH;
          end
        end
        default: begin
          if (!ov_r || out_ready) st_r <= S_IDLE;
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) used_r <= CW'(DEPTH))
    else $error("used count beyond depth");
  assert property (@(posedge clk) disable iff (!rst_n) q_ready |-> (st_r == S_IDLE))
    else $error("engine took a command while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
      (ov_r && !out_ready) |=> (ov_r && $stable(o_id_r)))
    else $error("result changed while stalled");

endmodule
`default_nettype wire
